/* src/pyp_pkg.sv */
package pyp_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned PairsW     = 11;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 11;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgSourceMode   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPairsPerLine = 1'd1;

  // source modes; the unused code behaves as planar 4:2:2
  localparam logic [ModeW-1:0] ModePlanar422 = 2'd0;
  localparam logic [ModeW-1:0] ModePlanar420 = 2'd1;
  localparam logic [ModeW-1:0] ModeInter420  = 2'd2;

  localparam logic [ModeW-1:0]  SourceModeReset   = ModePlanar420;
  localparam logic [PairsW-1:0] PairsPerLineReset = 11'd176;

  typedef struct packed {
    logic                frame_start;
    logic [ByteBits-1:0] luma_first;
    logic [ByteBits-1:0] luma_second;
    logic [ByteBits-1:0] chroma_first;
    logic [ByteBits-1:0] chroma_second;
  } pair_t;

  typedef struct packed {
    logic [4*ByteBits-1:0] packed_word;
    logic                  line_last;
  } word_t;

endpackage

/* src/pyp_pair_if.sv */
interface pyp_pair_if;
  import pyp_pkg::*;

  logic  valid;
  logic  ready;
  pair_t pair;

  modport source (output valid, output pair, input ready);
  modport sink   (input valid, input pair, output ready);
endinterface

/* src/pyp_word_if.sv */
interface pyp_word_if;
  import pyp_pkg::*;

  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

/* src/planar_yuv_to_yuyv_packer_core.sv */
// Packs one horizontal pixel pair per item into a YUY2 word (Y0, U, Y1, V
// from the low byte up). source_mode selects planar 4:2:2, planar 4:2:0 or
// interleaved-chroma 4:2:0; in the 4:2:0 modes the chroma of each even line
// is kept in a line store of MAX_LINE_PAIRS entries and reused on the odd
// line that follows, and the interleaved mode swaps the chroma bytes.
// frame_start on an item makes it column 0 of an even line. One item is
// taken every cycle while the output is not stalled; a result goes through
// the stage 1 register, which holds the synchronous read of the line store,
// and then the output register. The store needs no clearing after reset, but
// an odd-line column must have been written on the even line before it.
module planar_yuv_to_yuyv_packer_core #(
  parameter int unsigned MAX_LINE_PAIRS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pyp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pyp_pkg::CfgDataW-1:0]  cfg_data_i,
  pyp_pair_if.sink                      in_i,
  pyp_word_if.source                    out_o
);
  import pyp_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_LINE_PAIRS);
  // compare width wide enough for both the register and the depth
  localparam int unsigned LenW  = (AddrW + 1 > PairsW) ? AddrW + 1 : PairsW;
  localparam logic [LenW-1:0] MaxPairs = LenW'(MAX_LINE_PAIRS);

  // configuration
  logic [ModeW-1:0]  source_mode_q;
  logic [PairsW-1:0] pairs_per_line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_mode_q    <= SourceModeReset;
      pairs_per_line_q <= PairsPerLineReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgSourceMode:   source_mode_q    <= cfg_data_i[ModeW-1:0];
        CfgPairsPerLine: pairs_per_line_q <= cfg_data_i[PairsW-1:0];
        default: ;
      endcase
    end
  end

  // effective line length: zero acts as one, clipped to the store depth
  logic [LenW-1:0] pairs_ext;
  logic [LenW-1:0] eff_pairs;
  logic [LenW-1:0] last_col;

  always_comb begin
    pairs_ext = LenW'(pairs_per_line_q);
    priority if (pairs_ext == '0) begin
      eff_pairs = LenW'(1);
    end else if (pairs_ext > MaxPairs) begin
      eff_pairs = MaxPairs;
    end else begin
      eff_pairs = pairs_ext;
    end
    last_col = eff_pairs - LenW'(1);
  end

  // handshake: output register, then one stage that waits on the store read
  logic  out_valid_q;
  word_t out_word_q;
  logic  s1_valid_q;
  logic  out_free;
  logic  s1_adv;
  logic  in_acc;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc   = in_i.valid && in_i.ready;

  // stage 0: column and line parity, store access
  logic [AddrW-1:0] column_count_q;
  logic             odd_line_q;
  logic [AddrW-1:0] col;
  logic             odd;
  logic             sub420;
  logic             last;

  always_comb begin
    col    = in_i.pair.frame_start ? '0 : column_count_q;
    odd    = in_i.pair.frame_start ? 1'b0 : odd_line_q;
    sub420 = (source_mode_q == ModePlanar420) || (source_mode_q == ModeInter420);
    last   = LenW'(col) >= last_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      odd_line_q     <= 1'b0;
    end else if (in_acc) begin
      column_count_q <= last ? '0 : col + AddrW'(1);
      odd_line_q     <= last ? !odd : odd;
    end
  end

  logic [2*ByteBits-1:0] store_rdata;

  // write on even lines, read back on odd; the read of a column always comes
  // on a later item than its write, so no forwarding is needed
  pyp_chroma_store #(
    .Depth (MAX_LINE_PAIRS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && sub420 && !odd),
    .re_i    (in_acc && sub420 && odd),
    .addr_i  (col),
    .wdata_i ({in_i.pair.chroma_second, in_i.pair.chroma_first}),
    .rdata_o (store_rdata)
  );

  // stage 1 payload
  logic [ByteBits-1:0] y0_q, y1_q, c_first_q, c_second_q;
  logic                use_store_q;
  logic                swap_q;
  logic                last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      y0_q        <= in_i.pair.luma_first;
      y1_q        <= in_i.pair.luma_second;
      c_first_q   <= in_i.pair.chroma_first;
      c_second_q  <= in_i.pair.chroma_second;
      use_store_q <= sub420 && odd;
      swap_q      <= source_mode_q == ModeInter420;
      last_q      <= last;
    end
  end

  // chroma select and byte order
  logic [ByteBits-1:0] cf, cs, byte1, byte3;

  always_comb begin
    cf    = use_store_q ? store_rdata[ByteBits-1:0] : c_first_q;
    cs    = use_store_q ? store_rdata[2*ByteBits-1:ByteBits] : c_second_q;
    byte1 = swap_q ? cs : cf;
    byte3 = swap_q ? cf : cs;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_word_q.packed_word <= {byte3, y1_q, byte1, y0_q};
      out_word_q.line_last   <= last_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

endmodule

/* src/pyp_chroma_store.sv */
module pyp_chroma_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic                           re_i,
  input  logic [AddrW-1:0]               addr_i,
  input  logic [2*pyp_pkg::ByteBits-1:0] wdata_i,
  output logic [2*pyp_pkg::ByteBits-1:0] rdata_o
);
  import pyp_pkg::*;

  logic [2*ByteBits-1:0] mem [Depth];
  logic [2*ByteBits-1:0] rdata_q;

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pyp_pkg::*;

  // Line store depth the block is built with, and the mode code that the
  // package leaves unnamed (behaves as planar 4:2:2).
  localparam int unsigned        MaxPairs    = 1024;
  localparam logic [ModeW-1:0]   ModeUnused  = 2'd3;
  // Item to result: input register with the line store read, then output register.
  localparam int                 Latency     = 2;
  // Cycles without any handshake on either side before the run is declared hung.
  localparam int                 StallLimit  = 4000;
  localparam int                 RandomItems = 90;
  localparam int                 PrintCap    = 40;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  pyp_pair_if pair_ch ();
  pyp_word_if word_ch ();

  planar_yuv_to_yuyv_packer_core #(
    .MAX_LINE_PAIRS(MaxPairs)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (pair_ch.sink),
    .out_o       (word_ch.source)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the packer: register copies, line position and chroma line store.
  // chroma_seen marks store columns written on some even line since reset, so
  // that the stimulus never makes an odd line read an entry nobody wrote.
  // ---------------------------------------------------------------------------
  logic [ModeW-1:0]  cur_mode;
  logic [PairsW-1:0] cur_pairs;
  logic [9:0]        col_pos;
  logic              odd_row;
  logic [15:0]       chroma_store [MaxPairs];
  bit                chroma_seen  [MaxPairs];

  word_t             words_due [$];   // expected YUY2 words, oldest first
  int                err_count;
  bit                calm;            // no gaps or stalls while set

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_420(input logic [ModeW-1:0] m);
    return (m == ModePlanar420) || (m == ModeInter420);
  endfunction

  // Would this item make an odd 4:2:0 line fetch a column never stored?
  function automatic bit hits_blank_column(input pair_t p);
    return !p.frame_start && odd_row && is_420(cur_mode) && !chroma_seen[col_pos];
  endfunction

  // Works out the packed word for one accepted pair and advances the shadow.
  function automatic word_t pack_pair(input pair_t p);
    word_t         w;
    int            eff;
    logic [9:0]    c;
    logic [7:0]    u_byte;
    logic [7:0]    v_byte;
    eff = int'(cur_pairs);
    if (eff == 0) eff = 1;                           // zero length acts as one pair
    if (eff > int'(MaxPairs)) eff = int'(MaxPairs);  // clamp to store depth
    if (p.frame_start) begin
      col_pos = '0;
      odd_row = 1'b0;
    end
    c      = col_pos;
    u_byte = p.chroma_first;
    v_byte = p.chroma_second;
    if (is_420(cur_mode)) begin
      if (!odd_row) begin
        chroma_store[c] = {p.chroma_second, p.chroma_first};
        chroma_seen[c]  = 1'b1;
      end else begin
        // odd line: chroma inputs are ignored, the even line's pair is reused
        u_byte = chroma_store[c][7:0];
        v_byte = chroma_store[c][15:8];
      end
    end
    if (cur_mode == ModeInter420) begin
      w.packed_word = {u_byte, p.luma_second, v_byte, p.luma_first};
    end else begin
      w.packed_word = {v_byte, p.luma_second, u_byte, p.luma_first};
    end
    // a column at or past the last one ends the line, also after a length cut
    w.line_last = (int'(c) >= eff - 1);
    if (w.line_last) begin
      col_pos = '0;
      odd_row = ~odd_row;
    end else begin
      col_pos = c + 10'd1;
    end
    return w;
  endfunction

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pair_t rand_pair(input bit fs);
    pair_t p;
    p.frame_start   = fs;
    p.luma_first    = 8'($urandom);
    p.luma_second   = 8'($urandom);
    p.chroma_first  = 8'($urandom);
    p.chroma_second = 8'($urandom);
    return p;
  endfunction

  task automatic report_err(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    if (err_count < PrintCap)
      $display("%0t mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
    err_count++;
  endtask

  // Sends one pair and records its expected word once it is taken. valid is
  // never dropped after the handshake here, so back-to-back items keep it high.
  task automatic send_pair(input pair_t p);
    pair_t item;
    int    gap;
    item = p;
    if (hits_blank_column(item)) item.frame_start = 1'b1;
    gap = pick_gap();
    if (gap > 0) begin
      pair_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pair_ch.valid <= 1'b1;
    pair_ch.pair  <= item;
    do @(posedge clk_i); while (!pair_ch.ready);
    words_due.push_back(pack_pair(item));
  endtask

  task automatic send_fields(input bit fs, input logic [7:0] y0, input logic [7:0] y1,
                             input logic [7:0] cu, input logic [7:0] cv);
    pair_t p;
    p = '{frame_start: fs, luma_first: y0, luma_second: y1,
          chroma_first: cu, chroma_second: cv};
    send_pair(p);
  endtask

  // Input quiet and every expected word back, then a few cycles more.
  task automatic wait_idle();
    pair_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == CfgSourceMode) cur_mode  = val[ModeW-1:0];
    else                      cur_pairs = val[PairsW-1:0];
  endtask

  task automatic set_mode(input logic [ModeW-1:0] m);
    write_reg(CfgSourceMode, CfgDataW'(m));
  endtask

  task automatic set_pairs(input int n);
    write_reg(CfgPairsPerLine, CfgDataW'(n));
  endtask

  // --- directed tests --------------------------------------------------------

  // Reset values: planar 4:2:0, 176 pairs, so no line end in three items.
  task automatic test_reset_values();
    send_fields(1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF);
    send_fields(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send_fields(1'b0, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
  endtask

  task automatic test_planar_422();
    set_mode(ModePlanar422);
    set_pairs(2);
    send_fields(1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF);
    send_fields(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send_fields(1'b0, 8'h01, 8'h80, 8'h7F, 8'hFE);
    send_fields(1'b0, 8'hAA, 8'h55, 8'h55, 8'hAA);
  endtask

  // Even line stores chroma, odd line must ignore its own chroma inputs.
  task automatic test_chroma_reuse(input logic [ModeW-1:0] m);
    set_mode(m);
    send_fields(1'b1, 8'h10, 8'hEF, 8'h00, 8'hFF);
    send_fields(1'b0, 8'hEF, 8'h10, 8'hFF, 8'h00);
    send_fields(1'b0, 8'h20, 8'h30, 8'h99, 8'h66);
    send_fields(1'b0, 8'h40, 8'h50, 8'h12, 8'h34);
  endtask

  task automatic test_unused_mode();
    set_mode(ModeUnused);
    set_pairs(1);
    send_fields(1'b1, 8'h11, 8'h22, 8'h33, 8'h44);
    send_fields(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // Zero length acts as one; frame start mid-line restarts an even line.
  task automatic test_line_limits();
    set_mode(ModePlanar420);
    set_pairs(0);
    send_fields(1'b1, 8'h01, 8'h02, 8'h03, 8'h04);
    send_fields(1'b0, 8'h05, 8'h06, 8'h07, 8'h08);
    set_pairs(3);
    send_fields(1'b1, 8'hC0, 8'hC1, 8'hC2, 8'hC3);
    send_fields(1'b0, 8'hD0, 8'hD1, 8'hD2, 8'hD3);
    send_fields(1'b1, 8'hE0, 8'hE1, 8'hE2, 8'hE3);
  endtask

  // Oversized length clamps to the store depth: one full line fills every
  // column, then the length is cut while the odd line is under way.
  task automatic test_full_line();
    set_mode(ModeInter420);
    set_pairs(2047);
    send_pair(rand_pair(1'b1));
    repeat (MaxPairs + 5) send_pair(rand_pair(1'b0));
    set_pairs(2);
    repeat (6) send_pair(rand_pair(1'b0));
    set_pairs(MaxPairs);
    repeat (4) send_pair(rand_pair(1'b0));
  endtask

  // Phases of random settings; each runs a few frames of whole lines with
  // random content, some starting mid-frame, with the odd stray frame start.
  task automatic test_random_frames();
    int sent;
    int r;
    int eff;
    int frames;
    int lines;
    bit fresh;
    bit fs;
    sent = 0;
    while (sent < RandomItems) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) set_mode(ModeW'($urandom_range(0, 3)));
      r = $urandom_range(0, 99);
      if (r < 5)       set_pairs(0);
      else if (r < 12) set_pairs($urandom_range(17, 48));
      else if (r < 85) set_pairs($urandom_range(1, 8));
      // otherwise the length stays as it was
      eff = (cur_pairs == 0) ? 1 : int'(cur_pairs);
      if (eff > int'(MaxPairs)) eff = int'(MaxPairs);
      fresh  = ($urandom_range(0, 1) == 1);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames && sent < RandomItems; f++) begin
        lines = $urandom_range(2, 6);
        for (int k = 0; k < lines * eff && sent < RandomItems; k++) begin
          fs = (k == 0) && (f > 0 || fresh);
          if ($urandom_range(0, 49) == 0) fs = 1'b1;
          send_pair(rand_pair(fs));
          sent++;
        end
      end
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, and a check of every taken word.
  // ---------------------------------------------------------------------------
  initial begin : sink_ready
    int stall;
    stall = 0;
    word_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        word_ch.ready <= 1'b0;
        stall--;
      end else begin
        word_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 15) stall = pick_gap();
      end
    end
  end

  initial begin : word_check
    word_t got;
    word_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && word_ch.valid && word_ch.ready) begin
        got = word_ch.word;
        if (words_due.size() == 0) begin
          report_err("unexpected word", got.packed_word, '0);
        end else begin
          want = words_due.pop_front();
          if (got.packed_word !== want.packed_word)
            report_err("packed_word", got.packed_word, want.packed_word);
          if (got.line_last !== want.line_last)
            report_err("line_last", 32'(got.line_last), 32'(want.line_last));
        end
      end
    end
  end

  // Hang guard: any handshake on either side restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((pair_ch.valid && pair_ch.ready) || (word_ch.valid && word_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles", quiet);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    pair_ch.valid <= 1'b0;
    pair_ch.pair  <= '0;
    err_count = 0;
    calm      = 1'b0;
    cur_mode  = SourceModeReset;
    cur_pairs = PairsPerLineReset;
    col_pos   = '0;
    odd_row   = 1'b0;
    foreach (chroma_seen[i]) chroma_seen[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_planar_422();
    test_chroma_reuse(ModePlanar420);
    test_chroma_reuse(ModeInter420);
    test_unused_mode();
    test_line_limits();
    test_full_line();
    test_random_frames();

    wait_idle();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
